// ----- rtl/core/tpp_pkg.sv -----
// ----------------------------------------------------------------------------
// Thrust PI to PWM: shared package
// Types, register indexes and reset values shared by the thrust controller.
// ----------------------------------------------------------------------------
package tpp_pkg;

   // Default number of fraction bits of every fixed-point quantity.
   localparam int FRAC_BITS_DEF = 16;

   // PWM value sent whenever the controller does not run.
   localparam logic [11:0] IDLE_PWM = 12'd1300;

   // Run code that makes the controller compute a new command.
   localparam logic [3:0] RUN_CODE = 4'd1;

   // Register reset values.
   localparam logic signed [31:0] GOAL_RST  = 32'sd196608;
   localparam logic signed [31:0] KP_RST    = 32'sd131072;
   localparam logic signed [31:0] KI_RST    = 32'sd0;
   localparam logic signed [31:0] QUAD_RST  = 32'sd167936;
   localparam logic signed [31:0] LIN_RST   = 32'sd2139239;
   localparam logic signed [31:0] CONST_RST = 32'sd89112936;
   localparam logic [11:0]        MAX_RST   = 12'd1780;
   localparam logic [11:0]        FLOOR_RST = 12'd1380;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_GOAL  = 3'd0,
      REG_KP    = 3'd1,
      REG_KI    = 3'd2,
      REG_QUAD  = 3'd3,
      REG_LIN   = 3'd4,
      REG_CONST = 3'd5,
      REG_MAX   = 3'd6,
      REG_FLOOR = 3'd7
   } reg_index_type;

   // Current configuration as seen by the datapath.
   typedef struct packed {
      logic signed [31:0] goal;
      logic signed [31:0] kp;
      logic signed [31:0] ki;
      logic signed [31:0] quad;
      logic signed [31:0] lin;
      logic signed [31:0] cst;
      logic [11:0]        pwm_max;
      logic [11:0]        pwm_floor;
   } cfg_type;

endpackage

// ----- rtl/core/thrust_pi_to_pwm_core.sv -----
// ----------------------------------------------------------------------------
// Thrust PI to PWM controller
// PI thrust controller with a quadratic command-to-PWM map and PWM clamping.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one item per control sample: the measured thrust (Q format)
//   in req_tdata and the run code in req_tuser. rsp_ returns one item per
//   sample: the PWM value in rsp_tdata and the controller-active flag in
//   rsp_tuser. csr_ writes one configuration register per handshake and
//   never stalls; write it only while no sample is in progress.
//   An item with run code 1 updates the saturating error integral and runs
//   five fixed-point products through one shared 32x32 multiplier, one
//   after another. Its result is registered in the same cycle in which
//   req_tready rises again, so no new item is taken before then. Any other
//   run code yields the idle PWM value, with the integral untouched, and
//   such an item too is finished before the next one is taken.
//   The result sits in an output register; the next item is accepted while it
//   waits, and only the final step stalls when the receiver holds rsp_tready
//   low with the previous result still pending.
//   Reset (synchronous, active high) restores the register defaults, clears
//   the integral and empties the output register.
// ----------------------------------------------------------------------------
module thrust_pi_to_pwm_core import tpp_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] measured_thrust
   input  logic [3:0]  req_tuser,   // [3:0] run_code
   // Result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [11:0] pwm_value, [15:12] zero
   output logic [0:0]  rsp_tuser,   // [0] controller_active
   // Configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   typedef enum logic [10:0] {
      S_IDLE      = 11'b00000000001,
      S_INTEG     = 11'b00000000010,
      S_WAIT_KP   = 11'b00000000100,
      S_WAIT_KI   = 11'b00000001000,
      S_CLAMP     = 11'b00000010000,
      S_ISSUE_SQ  = 11'b00000100000,
      S_WAIT_SQ   = 11'b00001000000,
      S_WAIT_QUAD = 11'b00010000000,
      S_WAIT_LIN  = 11'b00100000000,
      S_SHIFT     = 11'b01000000000,
      S_DECIDE    = 11'b10000000000
   } state_type;

   localparam int          PWM_W      = 64 - FRAC_BITS;
   localparam logic [63:0] ROUND_BIAS = (64'd1 << FRAC_BITS) - 64'd1;

   cfg_type            cfg;
   logic               mul_start;
   logic               mul_done;
   logic signed [31:0] mul_a;
   logic signed [61:0] mul_b;
   logic signed [61:0] mul_res;

   state_type          state_ff, state_in;
   logic               active_ff;
   logic signed [32:0] err_ff;
   logic signed [47:0] sum_ff;
   logic signed [63:0] acc_ff;
   logic signed [31:0] cmd_ff;
   logic signed [PWM_W-1:0] pwm_ff;
   logic               rsp_valid_ff;
   logic [11:0]        rsp_pwm_ff;
   logic               rsp_active_ff;

   logic               req_accept;
   logic               out_free;
   logic signed [48:0] sum_next;
   logic signed [47:0] sum_sat;
   logic signed [63:0] mul_res_ext;
   logic signed [63:0] val_biased;
   logic signed [63:0] pwm_full;
   logic signed [PWM_W-1:0] max_ext;
   logic signed [PWM_W-1:0] floor_ext;
   logic [11:0]        pwm_pick;

   // Configuration registers.
   tpp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Shared multiplier.
   tpp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   // Handshakes.
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_pwm_ff};
   assign rsp_tuser  = rsp_active_ff;

   // Saturating update of the error integral.
   always_comb begin
      sum_next = $signed({sum_ff[47], sum_ff}) + $signed({{16{err_ff[32]}}, err_ff});
      if (sum_next[48] != sum_next[47]) begin
         sum_sat = sum_next[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end else begin
         sum_sat = sum_next[47:0];
      end
   end

   // Product results widened to the accumulator, and the final scaling.
   always_comb begin
      mul_res_ext = $signed({{2{mul_res[61]}}, mul_res});
      val_biased  = $signed(acc_ff + (acc_ff[63] ? ROUND_BIAS : 64'd0));
      pwm_full    = val_biased >>> FRAC_BITS;
      max_ext     = $signed({{(PWM_W-12){1'b0}}, cfg.pwm_max});
      floor_ext   = $signed({{(PWM_W-12){1'b0}}, cfg.pwm_floor});
   end

   // Clamp above, idle below the floor.
   always_comb begin
      if (!active_ff) begin
         pwm_pick = IDLE_PWM;
      end else if (pwm_ff > max_ext) begin
         pwm_pick = cfg.pwm_max;
      end else if (pwm_ff < floor_ext) begin
         pwm_pick = IDLE_PWM;
      end else begin
         pwm_pick = pwm_ff[11:0];
      end
   end

   // Multiplier issue: operands by step, started on entry or on completion.
   always_comb begin
      mul_start = 1'b0;
      mul_a     = cfg.kp;
      mul_b     = $signed({{29{err_ff[32]}}, err_ff});
      case (state_ff)
         S_INTEG: begin
            mul_start = 1'b1;
         end
         S_WAIT_KP: begin
            mul_start = mul_done;
            mul_a     = cfg.ki;
            mul_b     = $signed({{14{sum_ff[47]}}, sum_ff});
         end
         S_ISSUE_SQ: begin
            mul_start = 1'b1;
            mul_a     = cmd_ff;
            mul_b     = $signed({{30{cmd_ff[31]}}, cmd_ff});
         end
         S_WAIT_SQ: begin
            mul_start = mul_done;
            mul_a     = cfg.quad;
            mul_b     = mul_res;
         end
         S_WAIT_QUAD: begin
            mul_start = mul_done;
            mul_a     = cfg.lin;
            mul_b     = $signed({{30{cmd_ff[31]}}, cmd_ff});
         end
         default: begin
            mul_start = 1'b0;
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = (req_tuser == RUN_CODE) ? S_INTEG : S_DECIDE;
            end
         end
         S_INTEG:     state_in = S_WAIT_KP;
         S_WAIT_KP:   state_in = mul_done ? S_WAIT_KI : S_WAIT_KP;
         S_WAIT_KI:   state_in = mul_done ? S_CLAMP : S_WAIT_KI;
         S_CLAMP:     state_in = S_ISSUE_SQ;
         S_ISSUE_SQ:  state_in = S_WAIT_SQ;
         S_WAIT_SQ:   state_in = mul_done ? S_WAIT_QUAD : S_WAIT_SQ;
         S_WAIT_QUAD: state_in = mul_done ? S_WAIT_LIN : S_WAIT_QUAD;
         S_WAIT_LIN:  state_in = mul_done ? S_SHIFT : S_WAIT_LIN;
         S_SHIFT:     state_in = S_DECIDE;
         S_DECIDE:    state_in = out_free ? S_IDLE : S_DECIDE;
         default:     state_in = S_IDLE;
      endcase
   end

   // Control state, integral and output register valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= 48'sd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_INTEG) begin
            sum_ff <= sum_sat;
         end
         if ((state_ff == S_DECIDE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         active_ff <= (req_tuser == RUN_CODE);
         err_ff    <= $signed({cfg.goal[31], cfg.goal}) - $signed({req_tdata[31], req_tdata});
      end
      case (state_ff)
         S_INTEG: begin
            acc_ff <= $signed({{32{cfg.goal[31]}}, cfg.goal});
         end
         S_WAIT_KP, S_WAIT_KI, S_WAIT_LIN: begin
            if (mul_done) begin
               acc_ff <= acc_ff + mul_res_ext;
            end
         end
         S_CLAMP: begin
            if (acc_ff[63] && !(&acc_ff[62:31])) begin
               cmd_ff <= {1'b1, 31'd0};
            end else if (!acc_ff[63] && (|acc_ff[62:31])) begin
               cmd_ff <= {1'b0, {31{1'b1}}};
            end else begin
               cmd_ff <= acc_ff[31:0];
            end
         end
         S_WAIT_QUAD: begin
            if (mul_done) begin
               acc_ff <= $signed({{32{cfg.cst[31]}}, cfg.cst}) + mul_res_ext;
            end
         end
         S_SHIFT: begin
            pwm_ff <= pwm_full[PWM_W-1:0];
         end
         S_DECIDE: begin
            if (out_free) begin
               rsp_pwm_ff    <= pwm_pick;
               rsp_active_ff <= active_ff;
            end
         end
         default: begin
            acc_ff <= acc_ff;
         end
      endcase
   end

endmodule

// ----- rtl/core/tpp_csr.sv -----
// ----------------------------------------------------------------------------
// Thrust PI to PWM: configuration registers
// Holds the goal, gains, map coefficients and PWM limits written over the
// configuration channel.
// ----------------------------------------------------------------------------
module tpp_csr import tpp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   output cfg_type     cfg
);

   cfg_type cfg_ff;

   // The register file never stalls a write.
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // One register is updated per accepted write.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.goal      <= GOAL_RST;
         cfg_ff.kp        <= KP_RST;
         cfg_ff.ki        <= KI_RST;
         cfg_ff.quad      <= QUAD_RST;
         cfg_ff.lin       <= LIN_RST;
         cfg_ff.cst       <= CONST_RST;
         cfg_ff.pwm_max   <= MAX_RST;
         cfg_ff.pwm_floor <= FLOOR_RST;
      end else if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_GOAL:  cfg_ff.goal      <= $signed(csr_data);
            REG_KP:    cfg_ff.kp        <= $signed(csr_data);
            REG_KI:    cfg_ff.ki        <= $signed(csr_data);
            REG_QUAD:  cfg_ff.quad      <= $signed(csr_data);
            REG_LIN:   cfg_ff.lin       <= $signed(csr_data);
            REG_CONST: cfg_ff.cst       <= $signed(csr_data);
            REG_MAX:   cfg_ff.pwm_max   <= csr_data[11:0];
            REG_FLOOR: cfg_ff.pwm_floor <= csr_data[11:0];
            default:   cfg_ff           <= cfg_ff;
         endcase
      end
   end

endmodule

// ----- rtl/core/tpp_mul.sv -----
// ----------------------------------------------------------------------------
// Thrust PI to PWM: shared fixed-point multiplier
// Multiplies a 32-bit signed operand by a 62-bit signed operand with one
// 32x32 multiplier in two halves, scales the magnitude down by the fraction
// bits (truncating toward zero) and saturates the magnitude to 2^60.
// ----------------------------------------------------------------------------
module tpp_mul import tpp_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] op_a,
   input  logic signed [61:0] op_b,
   output logic               done,
   output logic signed [61:0] result
);

   typedef enum logic [4:0] {
      M_IDLE = 5'b00001,
      M_LO   = 5'b00010,
      M_HI   = 5'b00100,
      M_ACC  = 5'b01000,
      M_FIN  = 5'b10000
   } mstate_type;

   localparam logic [60:0] PROD_LIM = 61'd1 << 60;

   mstate_type         state_ff, state_in;
   logic [31:0]        a_ff;
   logic [61:0]        b_ff;
   logic               neg_ff;
   logic [63:0]        prod_ff;
   logic [95:0]        acc_ff;
   logic               done_ff;
   logic signed [61:0] result_ff;

   logic [31:0]        b_half;
   logic [63:0]        mul_out;
   logic [95:0]        scaled;
   logic               sat;
   logic [60:0]        mag_res;

   assign done   = done_ff;
   assign result = result_ff;

   // The single 32x32 multiplier takes the low half first, then the high half.
   always_comb begin
      b_half  = (state_ff == M_LO) ? b_ff[31:0] : {2'b00, b_ff[61:32]};
      mul_out = a_ff * b_half;
   end

   // Scale, saturate and restore the sign of the accumulated magnitude.
   always_comb begin
      scaled  = acc_ff >> FRAC_BITS;
      sat     = (|scaled[95:61]) || (scaled[60] && (|scaled[59:0]));
      mag_res = sat ? PROD_LIM : scaled[60:0];
   end

   // Step sequence of one multiplication.
   always_comb begin
      case (state_ff)
         M_IDLE:  state_in = start ? M_LO : M_IDLE;
         M_LO:    state_in = M_HI;
         M_HI:    state_in = M_ACC;
         M_ACC:   state_in = M_FIN;
         M_FIN:   state_in = M_IDLE;
         default: state_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == M_FIN);
      end
   end

   // Operand capture, partial products and accumulation.
   always_ff @(posedge clock) begin
      case (state_ff)
         M_IDLE: begin
            if (start) begin
               a_ff   <= op_a[31] ? 32'(-op_a) : 32'(op_a);
               b_ff   <= op_b[61] ? 62'(-op_b) : 62'(op_b);
               neg_ff <= op_a[31] ^ op_b[61];
            end
         end
         M_LO: begin
            prod_ff <= mul_out;
         end
         M_HI: begin
            acc_ff  <= {32'd0, prod_ff};
            prod_ff <= mul_out;
         end
         M_ACC: begin
            acc_ff <= acc_ff + {prod_ff, 32'd0};
         end
         M_FIN: begin
            result_ff <= neg_ff ? -$signed({1'b0, mag_res}) : $signed({1'b0, mag_res});
         end
         default: begin
            acc_ff <= acc_ff;
         end
      endcase
   end

endmodule

// ----- rtl/core/tpp_checker.sv -----
// ----------------------------------------------------------------------------
// Thrust PI to PWM: port checker
// Watches the ports of the controller and flags behavior that can never
// occur in a correct design.
// ----------------------------------------------------------------------------
module tpp_checker import tpp_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // A pending result is not withdrawn.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item withdrawn while stalled");

   // An accepted item keeps the block busy for at least the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input ready right after an accepted item");

   // Results not computed by the controller carry the idle PWM value.
   a_idle_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[11:0] == IDLE_PWM)
      else $error("inactive result without the idle PWM value");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result item valid right after reset");

endmodule

bind thrust_pi_to_pwm_core tpp_checker u_tpp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
